/* rtl/i2crw_pkg.sv */
// ----------------------------------------------------------------------------
// i2crw_pkg
// Types, codes and sizes shared by the I2C register read/write sequencer.
// ----------------------------------------------------------------------------
package i2crw_pkg;

    localparam int DEF_WRITE_DEPTH = 16;
    localparam int DEF_READ_DEPTH  = 16;

    localparam int CNT_W      = 5;   // write_count / read_count / positions
    localparam int STALL_W    = 17;
    localparam int TMO_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TMO_W-1:0] DEF_TIMEOUT = 16'd10000;

    // item modes
    localparam logic [1:0] MODE_POLL  = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_READ_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd3;

    // flag clear codes
    localparam logic [1:0] FCLR_NONE = 2'd0;
    localparam logic [1:0] FCLR_NACK = 2'd1;
    localparam logic [1:0] FCLR_RX   = 2'd2;

    // result codes
    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_NACK    = 2'd1;
    localparam logic [1:0] RES_TIMEOUT = 2'd2;

    // phase codes as seen on the result word
    localparam logic [3:0] PHC_IDLE     = 4'd0;
    localparam logic [3:0] PHC_START    = 4'd1;
    localparam logic [3:0] PHC_WSTART   = 4'd2;
    localparam logic [3:0] PHC_SEND     = 4'd3;
    localparam logic [3:0] PHC_RESTART  = 4'd4;
    localparam logic [3:0] PHC_WRESTART = 4'd5;
    localparam logic [3:0] PHC_READ     = 4'd6;
    localparam logic [3:0] PHC_WSTOP    = 4'd7;
    localparam logic [3:0] PHC_DONE     = 4'd8;
    localparam logic [3:0] PHC_ERROR    = 4'd9;

    typedef enum logic [9:0] {
        PH_IDLE     = 10'b00_0000_0001,
        PH_START    = 10'b00_0000_0010,
        PH_WSTART   = 10'b00_0000_0100,
        PH_SEND     = 10'b00_0000_1000,
        PH_RESTART  = 10'b00_0001_0000,
        PH_WRESTART = 10'b00_0010_0000,
        PH_READ     = 10'b00_0100_0000,
        PH_WSTOP    = 10'b00_1000_0000,
        PH_DONE     = 10'b01_0000_0000,
        PH_ERROR    = 10'b10_0000_0000
    } phase_t;

    // result word minus tx_byte, which comes from the buffer read register
    typedef struct packed {
        logic       cmd_start;
        logic       cmd_stop;
        logic       transmit_dir;
        logic       tx_valid;
        logic       rx_valid;
        logic [3:0] rx_index;
        logic [7:0] rx_byte;
        logic [1:0] flag_clear;
        logic       reinit_controller;
        logic [3:0] phase;
        logic [1:0] result_code;
    } rsp_t;

    function automatic logic [3:0] phase_code(input phase_t p);
        logic [3:0] c;
        case (p)
            PH_IDLE:     c = PHC_IDLE;
            PH_START:    c = PHC_START;
            PH_WSTART:   c = PHC_WSTART;
            PH_SEND:     c = PHC_SEND;
            PH_RESTART:  c = PHC_RESTART;
            PH_WRESTART: c = PHC_WRESTART;
            PH_READ:     c = PHC_READ;
            PH_WSTOP:    c = PHC_WSTOP;
            PH_DONE:     c = PHC_DONE;
            PH_ERROR:    c = PHC_ERROR;
            default:     c = PHC_IDLE;
        endcase
        return c;
    endfunction

endpackage

/* rtl/i2crw_if.sv */
// ----------------------------------------------------------------------------
// i2crw_req_if / i2crw_rsp_if
// Valid/ready channels of the sequencer: poll/load/start words in, commands out.
// ----------------------------------------------------------------------------
interface i2crw_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       stop_pending;
    logic       start_pending;
    logic       nack_seen;
    logic       tx_ready;
    logic       rx_ready;
    logic       bus_busy;
    logic [7:0] rx_data;
    logic [3:0] load_index;
    logic [7:0] load_byte;

    modport source (
        output valid, mode, stop_pending, start_pending, nack_seen, tx_ready,
               rx_ready, bus_busy, rx_data, load_index, load_byte,
        input  ready
    );
    modport sink (
        input  valid, mode, stop_pending, start_pending, nack_seen, tx_ready,
               rx_ready, bus_busy, rx_data, load_index, load_byte,
        output ready
    );
endinterface

interface i2crw_rsp_if;
    logic       valid;
    logic       ready;
    logic       cmd_start;
    logic       cmd_stop;
    logic       transmit_dir;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [3:0] rx_index;
    logic [7:0] rx_byte;
    logic [1:0] flag_clear;
    logic       reinit_controller;
    logic [3:0] phase;
    logic [1:0] result_code;

    modport source (
        output valid, cmd_start, cmd_stop, transmit_dir, tx_valid, tx_byte,
               rx_valid, rx_index, rx_byte, flag_clear, reinit_controller,
               phase, result_code,
        input  ready
    );
    modport sink (
        input  valid, cmd_start, cmd_stop, transmit_dir, tx_valid, tx_byte,
               rx_valid, rx_index, rx_byte, flag_clear, reinit_controller,
               phase, result_code,
        output ready
    );
endinterface

/* rtl/i2crw_wbuf.sv */
// ----------------------------------------------------------------------------
// i2crw_wbuf
// Transmit byte buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module i2crw_wbuf
#(
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic          rd_take,   // 0: load zero into the read register
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rd_take ? mem[rd_addr] : 8'd0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/i2c_register_read_write_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_register_read_write_sequencer
// Polled I2C master sequencer: write buffered bytes, repeated start, read.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          word
//  req      in   valid/ready        mode + controller status / buffer load
//  rsp      out  valid/ready        controller commands, phase, result code
//  cfg      in   cfg_we (no stall)  cfg_index, cfg_data
//
//  One word per clock unless rsp stalls. Each accepted word updates the
//  sequencer state and output register; rsp shows its result next cycle.
//  req.ready = !rsp.valid || rsp.ready, so the output register alone sets
//  back-pressure. tx_byte comes from the buffer's registered read port,
//  loaded in the same edge as the rest of the result.
//  Reset clears phase, counters, positions and result code; buffer contents
//  stay undefined until loaded.
// ----------------------------------------------------------------------------
module i2c_register_read_write_sequencer
    import i2crw_pkg::*;
#(
    parameter int WRITE_DEPTH = DEF_WRITE_DEPTH,
    parameter int READ_DEPTH  = DEF_READ_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    i2crw_req_if.sink             req,
    i2crw_rsp_if.source           rsp
);

    localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
    localparam logic [STALL_W-1:0] STALL_MAX = '1;

    // configuration; the target address only feeds the controller's address
    // lines, which sit outside this block, so no copy is kept here
    logic [CNT_W-1:0] write_count_reg;
    logic [CNT_W-1:0] read_count_reg;
    logic [TMO_W-1:0] timeout_reg;

    phase_t             phase_reg,       phase_next;
    logic               start_req_reg,   start_req_next;
    logic [STALL_W-1:0] stall_reg,       stall_next;
    logic [CNT_W-1:0]   wpos_reg,        wpos_next;
    logic [CNT_W-1:0]   rpos_reg,        rpos_next;
    logic [1:0]         result_reg,      result_next;
    logic               out_valid_reg;
    rsp_t               rsp_reg,         rsp_next;

    logic               in_fire;
    logic               tx_take;
    logic [CNT_W-1:0]   nw;
    logic [CNT_W-1:0]   nr;
    logic [STALL_W-1:0] stall_inc;
    logic [CNT_W-1:0]   rpos_inc;
    logic               buf_we;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign in_fire   = req.valid && req.ready;

    assign nw = (write_count_reg > WRITE_DEPTH) ? CNT_W'(WRITE_DEPTH) : write_count_reg;
    assign nr = (read_count_reg > READ_DEPTH) ? CNT_W'(READ_DEPTH) : read_count_reg;

    assign stall_inc = (stall_reg == STALL_MAX) ? stall_reg : stall_reg + 1'b1;
    assign rpos_inc  = (rpos_reg == '1) ? rpos_reg : rpos_reg + 1'b1;

    assign buf_we = in_fire && (req.mode == MODE_LOAD) && (32'(req.load_index) < WRITE_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_count_reg <= '0;
            read_count_reg  <= '0;
            timeout_reg     <= DEF_TIMEOUT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WRITE_COUNT: write_count_reg <= cfg_data[CNT_W-1:0];
                REG_READ_COUNT:  read_count_reg  <= cfg_data[CNT_W-1:0];
                REG_TIMEOUT:     timeout_reg     <= cfg_data[TMO_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        start_req_next = start_req_reg;
        stall_next     = stall_reg;
        wpos_next      = wpos_reg;
        rpos_next      = rpos_reg;
        result_next    = result_reg;
        tx_take        = 1'b0;
        rsp_next       = '0;

        case (req.mode)
            MODE_START:
            begin
                wpos_next      = '0;
                rpos_next      = '0;
                start_req_next = 1'b1;
                stall_next     = '0;
            end
            MODE_POLL:
            begin
                if (phase_reg == PH_IDLE || phase_reg == PH_DONE)
                begin
                    if (start_req_reg)
                    begin
                        phase_next     = PH_START;
                        start_req_next = 1'b0;
                        result_next    = RES_OK;
                    end
                end
                else if (phase_reg == PH_ERROR)
                begin
                    rsp_next.reinit_controller = 1'b1;
                    stall_next  = '0;
                    phase_next  = PH_IDLE;
                    result_next = RES_OK;
                end
                else
                begin
                    stall_next = stall_inc;
                    if (stall_inc > {1'b0, timeout_reg})
                    begin
                        phase_next  = PH_ERROR;
                        result_next = RES_TIMEOUT;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_START:
                            begin
                                if (!req.stop_pending)
                                begin
                                    rsp_next.cmd_start    = 1'b1;
                                    rsp_next.transmit_dir = (nw != '0);
                                    phase_next = PH_WSTART;
                                    stall_next = '0;
                                end
                            end
                            PH_WSTART:
                            begin
                                if (!req.start_pending)
                                begin
                                    if (nw != '0)
                                    begin
                                        phase_next = PH_SEND;
                                    end
                                    else if (nr != '0)
                                    begin
                                        phase_next = PH_RESTART;
                                    end
                                    else
                                    begin
                                        rsp_next.cmd_stop = 1'b1;
                                        phase_next = PH_WSTOP;
                                    end
                                    stall_next = '0;
                                end
                                // NACK wins over start completion
                                if (req.nack_seen)
                                begin
                                    rsp_next.flag_clear = FCLR_NACK;
                                    rsp_next.cmd_stop   = 1'b1;
                                    phase_next  = PH_DONE;
                                    result_next = RES_NACK;
                                end
                            end
                            PH_SEND:
                            begin
                                if (req.tx_ready)
                                begin
                                    if (wpos_reg < nw)
                                    begin
                                        rsp_next.tx_valid = 1'b1;
                                        tx_take   = 1'b1;
                                        wpos_next = wpos_reg + 1'b1;
                                    end
                                    else if (nr != '0)
                                    begin
                                        phase_next = PH_RESTART;
                                    end
                                    else
                                    begin
                                        rsp_next.cmd_stop = 1'b1;
                                        phase_next = PH_WSTOP;
                                    end
                                    stall_next = '0;
                                end
                            end
                            PH_RESTART:
                            begin
                                rsp_next.cmd_start  = 1'b1;
                                rsp_next.flag_clear = FCLR_RX;
                                // single-byte read: stop goes out with the restart
                                if (nr <= CNT_W'(1))
                                begin
                                    rsp_next.cmd_stop = 1'b1;
                                end
                                phase_next = PH_WRESTART;
                                stall_next = '0;
                            end
                            PH_WRESTART:
                            begin
                                if (!req.start_pending)
                                begin
                                    phase_next = (nr <= CNT_W'(1)) ? PH_WSTOP : PH_READ;
                                    stall_next = '0;
                                end
                            end
                            PH_READ:
                            begin
                                if (req.rx_ready)
                                begin
                                    rsp_next.rx_valid = 1'b1;
                                    rsp_next.rx_index = rpos_reg[3:0];
                                    rsp_next.rx_byte  = req.rx_data;
                                    rpos_next = rpos_inc;
                                    // stop before the last byte
                                    if ((CNT_W+1)'(rpos_inc) + 1'b1 >= (CNT_W+1)'(nr))
                                    begin
                                        rsp_next.cmd_stop = 1'b1;
                                        phase_next = PH_WSTOP;
                                    end
                                    stall_next = '0;
                                end
                            end
                            PH_WSTOP:
                            begin
                                if (!req.stop_pending && !req.bus_busy)
                                begin
                                    if (nr != '0)
                                    begin
                                        rsp_next.rx_valid = 1'b1;
                                        rsp_next.rx_index = rpos_reg[3:0];
                                        rsp_next.rx_byte  = req.rx_data;
                                    end
                                    phase_next  = PH_DONE;
                                    result_next = RES_OK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: ;   // buffer load or unused mode: commands stay zero
        endcase

        rsp_next.phase       = phase_code(phase_next);
        rsp_next.result_code = result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            start_req_reg <= 1'b0;
            stall_reg     <= '0;
            wpos_reg      <= '0;
            rpos_reg      <= '0;
            result_reg    <= RES_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg     <= phase_next;
                start_req_reg <= start_req_next;
                stall_reg     <= stall_next;
                wpos_reg      <= wpos_next;
                rpos_reg      <= rpos_next;
                result_reg    <= result_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    i2crw_wbuf #(
        .DEPTH (WRITE_DEPTH),
        .AW    (AW)
    ) u_wbuf (
        .clk     (clk),
        .wr_en   (buf_we),
        .wr_addr (AW'(req.load_index)),
        .wr_data (req.load_byte),
        .rd_en   (in_fire),
        .rd_take (tx_take),
        .rd_addr (AW'(wpos_reg)),
        .rd_data (rsp.tx_byte)
    );

    assign rsp.valid             = out_valid_reg;
    assign rsp.cmd_start         = rsp_reg.cmd_start;
    assign rsp.cmd_stop          = rsp_reg.cmd_stop;
    assign rsp.transmit_dir      = rsp_reg.transmit_dir;
    assign rsp.tx_valid          = rsp_reg.tx_valid;
    assign rsp.rx_valid          = rsp_reg.rx_valid;
    assign rsp.rx_index          = rsp_reg.rx_index;
    assign rsp.rx_byte           = rsp_reg.rx_byte;
    assign rsp.flag_clear        = rsp_reg.flag_clear;
    assign rsp.reinit_controller = rsp_reg.reinit_controller;
    assign rsp.phase             = rsp_reg.phase;
    assign rsp.result_code       = rsp_reg.result_code;

    // every accepted word yields a result in the next cycle
    a_fire_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> rsp.valid)
        else $error("accepted word produced no result");

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase register not one-hot");

    a_tx_in_send: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.tx_valid |-> rsp.phase == PHC_SEND)
        else $error("transmit byte outside send phase");

    a_timeout_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.result_code == RES_TIMEOUT |-> rsp.phase == PHC_ERROR)
        else $error("timeout code outside error phase");

    a_wpos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && tx_take |=> wpos_reg <= nw)
        else $error("write position ran past write count");

endmodule

/* test/i2c_register_read_write_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// i2c_register_read_write_sequencer_tb
// Self-checking bench for the polled I2C write/repeated-start/read sequencer.
// Poll, load and start words go in over valid/ready, and each command word
// that comes out is checked against an in-bench model of the sequencer. The
// run walks through several register settings: count extremes, counts past
// the buffer depth, address-only transfers, zero and tiny timeouts. It keeps
// random sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module i2c_register_read_write_sequencer_tb;
    import i2crw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PATTERN  = 2;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [1:0] mode;
        logic       stop_pending;
        logic       start_pending;
        logic       nack_seen;
        logic       tx_ready;
        logic       rx_ready;
        logic       bus_busy;
        logic [7:0] rx_data;
        logic [3:0] load_index;
        logic [7:0] load_byte;
    } poll_word_t;

    typedef struct packed {
        logic       cmd_start;
        logic       cmd_stop;
        logic       transmit_dir;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [3:0] rx_index;
        logic [7:0] rx_byte;
        logic [1:0] flag_clear;
        logic       reinit_controller;
        logic [3:0] phase;
        logic [1:0] result_code;
    } seq_cmd_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    i2crw_req_if req_ch ();
    i2crw_rsp_if rsp_ch ();

    i2c_register_read_write_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // model of the sequencer: registers
    logic [6:0]         target_addr  = '0;
    logic [CNT_W-1:0]   wr_count_reg = '0;
    logic [CNT_W-1:0]   rd_count_reg = '0;
    logic [TMO_W-1:0]   poll_limit   = DEF_TIMEOUT;

    // model of the sequencer: state
    logic [3:0]         seq_phase   = PHC_IDLE;
    logic               start_armed = 1'b0;
    logic [STALL_W-1:0] idle_polls  = '0;
    logic [CNT_W-1:0]   tx_pos      = '0;
    logic [CNT_W-1:0]   rx_pos      = '0;
    logic [7:0]         tx_buffer [DEF_WRITE_DEPTH];
    logic [1:0]         last_code   = RES_OK;

    poll_word_t poll_words [$];
    seq_cmd_t   pending_cmds [$];

    bit word_taken    = 1'b0;
    bit sender_gaps   = 1'b0;
    int rx_mode       = RX_ALWAYS;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    logic [10:0] stall_pattern = 11'b101_1001_1100;

    int mismatch_count  = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int settings_used   = 0;
    int n_clean         = 0;
    int n_nack          = 0;
    int n_timeout       = 0;
    int n_tx            = 0;
    int n_rx            = 0;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // one word through the sequencer model; returns the command word it causes
    task automatic next_commands(input poll_word_t w, output seq_cmd_t r);
        logic [CNT_W-1:0] nw;
        logic [CNT_W-1:0] nr;
        r  = '0;
        nw = (wr_count_reg > DEF_WRITE_DEPTH) ? CNT_W'(DEF_WRITE_DEPTH) : wr_count_reg;
        nr = (rd_count_reg > DEF_READ_DEPTH) ? CNT_W'(DEF_READ_DEPTH) : rd_count_reg;
        case (w.mode)
            MODE_LOAD:
                tx_buffer[w.load_index] = w.load_byte;
            MODE_START:
            begin
                tx_pos      = '0;
                rx_pos      = '0;
                start_armed = 1'b1;
                idle_polls  = '0;
            end
            MODE_POLL:
            begin
                if (seq_phase == PHC_IDLE || seq_phase == PHC_DONE)
                begin
                    if (start_armed)
                    begin
                        seq_phase   = PHC_START;
                        start_armed = 1'b0;
                        last_code   = RES_OK;
                    end
                end
                else if (seq_phase == PHC_ERROR)
                begin
                    r.reinit_controller = 1'b1;
                    idle_polls = '0;
                    seq_phase  = PHC_IDLE;
                    last_code  = RES_OK;
                end
                else
                begin
                    if (idle_polls != '1)
                        idle_polls++;
                    if (idle_polls > poll_limit)
                    begin
                        seq_phase = PHC_ERROR;
                        last_code = RES_TIMEOUT;
                        n_timeout++;
                    end
                    else
                    begin
                        case (seq_phase)
                            PHC_START:
                                if (!w.stop_pending)
                                begin
                                    r.cmd_start    = 1'b1;
                                    r.transmit_dir = (nw != 0);
                                    seq_phase  = PHC_WSTART;
                                    idle_polls = '0;
                                end
                            PHC_WSTART:
                            begin
                                if (!w.start_pending)
                                begin
                                    if (nw != 0)
                                        seq_phase = PHC_SEND;
                                    else if (nr != 0)
                                        seq_phase = PHC_RESTART;
                                    else
                                    begin
                                        // address-only transfer
                                        r.cmd_stop = 1'b1;
                                        seq_phase  = PHC_WSTOP;
                                    end
                                    idle_polls = '0;
                                end
                                // NACK wins over start completion
                                if (w.nack_seen)
                                begin
                                    r.flag_clear = FCLR_NACK;
                                    r.cmd_stop   = 1'b1;
                                    seq_phase    = PHC_DONE;
                                    last_code    = RES_NACK;
                                    n_nack++;
                                end
                            end
                            PHC_SEND:
                                if (w.tx_ready)
                                begin
                                    if (tx_pos < nw)
                                    begin
                                        r.tx_valid = 1'b1;
                                        r.tx_byte  = tx_buffer[tx_pos[3:0]];
                                        tx_pos++;
                                        n_tx++;
                                    end
                                    else if (nr != 0)
                                        seq_phase = PHC_RESTART;
                                    else
                                    begin
                                        r.cmd_stop = 1'b1;
                                        seq_phase  = PHC_WSTOP;
                                    end
                                    idle_polls = '0;
                                end
                            PHC_RESTART:
                            begin
                                r.cmd_start  = 1'b1;
                                r.flag_clear = FCLR_RX;
                                // single-byte read: stop goes out with the restart
                                if (nr <= 1)
                                    r.cmd_stop = 1'b1;
                                seq_phase  = PHC_WRESTART;
                                idle_polls = '0;
                            end
                            PHC_WRESTART:
                                if (!w.start_pending)
                                begin
                                    seq_phase  = (nr <= 1) ? PHC_WSTOP : PHC_READ;
                                    idle_polls = '0;
                                end
                            PHC_READ:
                                if (w.rx_ready)
                                begin
                                    r.rx_valid = 1'b1;
                                    r.rx_index = rx_pos[3:0];
                                    r.rx_byte  = w.rx_data;
                                    n_rx++;
                                    if (rx_pos < 31)
                                        rx_pos++;
                                    if (rx_pos + 1 >= nr)
                                    begin
                                        r.cmd_stop = 1'b1;
                                        seq_phase  = PHC_WSTOP;
                                    end
                                    idle_polls = '0;
                                end
                            PHC_WSTOP:
                                if (!w.stop_pending && !w.bus_busy)
                                begin
                                    // last byte is taken once the stop is done
                                    if (nr != 0)
                                    begin
                                        r.rx_valid = 1'b1;
                                        r.rx_index = rx_pos[3:0];
                                        r.rx_byte  = w.rx_data;
                                        n_rx++;
                                    end
                                    seq_phase = PHC_DONE;
                                    last_code = RES_OK;
                                    n_clean++;
                                end
                            default:
                                ;
                        endcase
                    end
                end
            end
            default:
                ;
        endcase
        r.phase       = seq_phase;
        r.result_code = last_code;
    endtask

    function automatic poll_word_t rand_word(input logic [1:0] mode);
        poll_word_t w;
        w.mode          = mode;
        w.stop_pending  = 1'($urandom_range(0, 1));
        w.start_pending = 1'($urandom_range(0, 1));
        w.nack_seen     = 1'($urandom_range(0, 1));
        w.tx_ready      = 1'($urandom_range(0, 1));
        w.rx_ready      = 1'($urandom_range(0, 1));
        w.bus_busy      = 1'($urandom_range(0, 1));
        w.rx_data       = 8'($urandom_range(0, 255));
        w.load_index    = 4'($urandom_range(0, 15));
        w.load_byte     = 8'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic poll_word_t status_poll(input logic stp, input logic stt,
                                               input logic nack, input logic xrdy,
                                               input logic rrdy, input logic bb,
                                               input logic [7:0] rxd);
        poll_word_t w;
        w = rand_word(MODE_POLL);
        w.stop_pending  = stp;
        w.start_pending = stt;
        w.nack_seen     = nack;
        w.tx_ready      = xrdy;
        w.rx_ready      = rrdy;
        w.bus_busy      = bb;
        w.rx_data       = rxd;
        return w;
    endfunction

    function automatic poll_word_t load_word(input logic [3:0] idx, input logic [7:0] value);
        poll_word_t w;
        w = rand_word(MODE_LOAD);
        w.load_index = idx;
        w.load_byte  = value;
        return w;
    endfunction

    // status leaning toward progress in every phase at once
    function automatic poll_word_t biased_poll();
        return status_poll($urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
                           $urandom_range(0, 24) == 0, $urandom_range(0, 5) != 0,
                           $urandom_range(0, 5) != 0, $urandom_range(0, 5) == 0,
                           8'($urandom_range(0, 255)));
    endfunction

    function automatic poll_word_t noise_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5)
            return rand_word(MODE_POLL);
        else if (pick <= 7)
            return rand_word(MODE_LOAD);
        else if (pick == 8)
            return rand_word(MODE_SPARE);
        return rand_word(MODE_START);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                             input int width);
        logic [CFG_DATA_W-1:0] data;
        // junk above the register width must be dropped
        data = CFG_DATA_W'(($urandom << width) | value);
        case (idx)
            REG_SLAVE_ADDR:  target_addr  = data[6:0];
            REG_WRITE_COUNT: wr_count_reg = data[CNT_W-1:0];
            REG_READ_COUNT:  rd_count_reg = data[CNT_W-1:0];
            REG_TIMEOUT:     poll_limit   = data[TMO_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_registers(input int unsigned addr, input int unsigned wc,
                                 input int unsigned rc, input int unsigned tmo);
        write_reg(REG_SLAVE_ADDR, addr, 7);
        write_reg(REG_WRITE_COUNT, wc, CNT_W);
        write_reg(REG_READ_COUNT, rc, CNT_W);
        write_reg(REG_TIMEOUT, tmo, TMO_W);
        settings_used++;
    endtask

    // waits until every word is sent and every command word is back, then idles
    task automatic drain();
        while (poll_words.size() != 0 || req_ch.valid || pending_cmds.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_setting(input int unsigned addr, input int unsigned wc,
                               input int unsigned rc, input int unsigned tmo,
                               input int words, input bit gaps, input int rx_pattern,
                               input bit hold);
        int made;
        int span;
        int nw;
        int nr;
        poll_word_t w;
        drain();
        set_registers(addr, wc, rc, tmo);
        sender_gaps = gaps;
        rx_mode     = rx_pattern;
        nw   = (wc > DEF_WRITE_DEPTH) ? DEF_WRITE_DEPTH : wc;
        nr   = (rc > DEF_READ_DEPTH) ? DEF_READ_DEPTH : rc;
        made = 0;
        while (made < words)
        begin
            poll_words.push_back(rand_word(MODE_START));
            made++;
            span = 2 * (nw + nr) + 6 + $urandom_range(0, 6);
            for (int k = 0; k < span; k++)
            begin
                w = ($urandom_range(0, 99) < 85) ? biased_poll() : noise_word();
                poll_words.push_back(w);
                if (w.mode != MODE_SPARE)
                    made++;
            end
        end
        if (hold)
        begin
            @(posedge clk);
            hold_requests++;
        end
    endtask

    // sender: words in bursts, with random gaps in between when gaps are on
    always @(negedge clk)
    begin : feed
        poll_word_t w;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || word_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (poll_words.size() != 0)
            begin
                w = poll_words.pop_front();
                req_ch.valid         <= 1'b1;
                req_ch.mode          <= w.mode;
                req_ch.stop_pending  <= w.stop_pending;
                req_ch.start_pending <= w.start_pending;
                req_ch.nack_seen     <= w.nack_seen;
                req_ch.tx_ready      <= w.tx_ready;
                req_ch.rx_ready      <= w.rx_ready;
                req_ch.bus_busy      <= w.bus_busy;
                req_ch.rx_data       <= w.rx_data;
                req_ch.load_index    <= w.load_index;
                req_ch.load_byte     <= w.load_byte;
                if (sender_gaps)
                begin
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // receiver: stall pattern per setting, plus the long hold-off on request
    always @(negedge clk)
    begin : sink
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (rx_mode == RX_RANDOM)
            rsp_ch.ready <= ($urandom_range(0, 9) >= 3);
        else if (rx_mode == RX_PATTERN)
        begin
            rsp_ch.ready  <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[10:1]};
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : watch
        poll_word_t w;
        seq_cmd_t   got;
        seq_cmd_t   want;
        seq_cmd_t   pred;
        word_taken = rst_n && req_ch.valid && req_ch.ready;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.cmd_start         = rsp_ch.cmd_start;
            got.cmd_stop          = rsp_ch.cmd_stop;
            got.transmit_dir      = rsp_ch.transmit_dir;
            got.tx_valid          = rsp_ch.tx_valid;
            got.tx_byte           = rsp_ch.tx_byte;
            got.rx_valid          = rsp_ch.rx_valid;
            got.rx_index          = rsp_ch.rx_index;
            got.rx_byte           = rsp_ch.rx_byte;
            got.flag_clear        = rsp_ch.flag_clear;
            got.reinit_controller = rsp_ch.reinit_controller;
            got.phase             = rsp_ch.phase;
            got.result_code       = rsp_ch.result_code;
            results_checked++;
            if (pending_cmds.size() == 0)
                report_mismatch("command word with none expected, phase", 8'(got.phase),
                                8'd0);
            else
            begin
                want = pending_cmds.pop_front();
                if (got.cmd_start !== want.cmd_start)
                    report_mismatch("cmd_start", 8'(got.cmd_start), 8'(want.cmd_start));
                if (got.cmd_stop !== want.cmd_stop)
                    report_mismatch("cmd_stop", 8'(got.cmd_stop), 8'(want.cmd_stop));
                if (got.transmit_dir !== want.transmit_dir)
                    report_mismatch("transmit_dir", 8'(got.transmit_dir),
                                    8'(want.transmit_dir));
                if (got.tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
                if (got.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
                if (got.rx_valid !== want.rx_valid)
                    report_mismatch("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
                if (got.rx_index !== want.rx_index)
                    report_mismatch("rx_index", 8'(got.rx_index), 8'(want.rx_index));
                if (got.rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
                if (got.flag_clear !== want.flag_clear)
                    report_mismatch("flag_clear", 8'(got.flag_clear), 8'(want.flag_clear));
                if (got.reinit_controller !== want.reinit_controller)
                    report_mismatch("reinit_controller", 8'(got.reinit_controller),
                                    8'(want.reinit_controller));
                if (got.phase !== want.phase)
                    report_mismatch("phase", 8'(got.phase), 8'(want.phase));
                if (got.result_code !== want.result_code)
                    report_mismatch("result_code", 8'(got.result_code),
                                    8'(want.result_code));
            end
        end
        if (word_taken)
        begin
            w.mode          = req_ch.mode;
            w.stop_pending  = req_ch.stop_pending;
            w.start_pending = req_ch.start_pending;
            w.nack_seen     = req_ch.nack_seen;
            w.tx_ready      = req_ch.tx_ready;
            w.rx_ready      = req_ch.rx_ready;
            w.bus_busy      = req_ch.bus_busy;
            w.rx_data       = req_ch.rx_data;
            w.load_index    = req_ch.load_index;
            w.load_byte     = req_ch.load_byte;
            next_commands(w, pred);
            pending_cmds.push_back(pred);
            words_sent++;
        end
    end

    initial
    begin
        #2_000_000;
        $display("i2c_register_read_write_sequencer regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned wc;
        int unsigned rc;
        int unsigned tmo;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        rst_n                = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: fill the whole buffer first so no send reads an empty entry
        set_registers(127, 1, 1, DEF_TIMEOUT);
        sender_gaps = 1'b1;
        rx_mode     = RX_RANDOM;
        for (int i = 0; i < DEF_WRITE_DEPTH; i++)
            poll_words.push_back(load_word(4'(i), (i == 0) ? 8'h00 :
                                                  (i == 15) ? 8'hFF :
                                                  8'($urandom_range(0, 255))));
        poll_words.push_back(rand_word(MODE_SPARE));
        poll_words.push_back(rand_word(MODE_START));
        // single-byte write, single-byte read with stop on the restart
        poll_words.push_back(status_poll(1, 0, 0, 0, 0, 1, 8'h00));
        poll_words.push_back(status_poll(0, 1, 0, 1, 1, 1, 8'h00));
        poll_words.push_back(status_poll(1, 1, 0, 0, 0, 1, 8'h00));
        poll_words.push_back(status_poll(0, 0, 0, 0, 0, 0, 8'h00));
        poll_words.push_back(status_poll(0, 0, 0, 1, 0, 0, 8'h00));
        poll_words.push_back(status_poll(0, 0, 0, 1, 0, 0, 8'h00));
        poll_words.push_back(status_poll(1, 1, 1, 1, 1, 1, 8'hFF));
        poll_words.push_back(status_poll(1, 0, 1, 1, 1, 1, 8'hFF));
        poll_words.push_back(status_poll(0, 1, 1, 0, 0, 0, 8'hFF));

        run_setting(0, 4, 3, DEF_TIMEOUT, 150, 1'b1, RX_RANDOM, 1'b0);
        run_setting(85, 0, 0, DEF_TIMEOUT, 100, 1'b0, RX_ALWAYS, 1'b0);
        run_setting(42, 16, 16, 65535, 220, 1'b1, RX_PATTERN, 1'b0);
        run_setting(127, 0, 1, 0, 80, 1'b1, RX_RANDOM, 1'b0);
        run_setting(19, 31, 31, 3, 150, 1'b1, RX_PATTERN, 1'b0);
        run_setting(1, 2, 1, 1, 150, 1'b0, RX_RANDOM, 1'b0);
        run_setting(51, 3, 5, 20, 150, 1'b1, RX_ALWAYS, 1'b1);
        for (int s = 0; s < 5; s++)
        begin
            wc  = $urandom_range(0, 31);
            rc  = $urandom_range(0, 31);
            tmo = $urandom_range(0, 1) ? DEF_TIMEOUT : $urandom_range(0, 40);
            run_setting($urandom_range(0, 127), wc, rc, tmo, 70, 1'($urandom_range(0, 1)),
                        $urandom_range(RX_ALWAYS, RX_PATTERN), 1'b0);
        end
        drain();
        repeat (10) @(posedge clk);

        $display("covered %0d words and %0d command words over %0d register settings",
                 words_sent, results_checked, settings_used);
        $display("%0d clean transfers, %0d NACK aborts, %0d timeouts, %0d bytes out, %0d in",
                 n_clean, n_nack, n_timeout, n_tx, n_rx);
        if (mismatch_count == 0)
            $display("i2c_register_read_write_sequencer regression: pass");
        else
            $display("i2c_register_read_write_sequencer regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/i2crw_pkg.sv
rtl/i2crw_if.sv
rtl/i2crw_wbuf.sv
rtl/i2c_register_read_write_sequencer.sv
test/i2c_register_read_write_sequencer_tb.sv
